/* design/timed_diverter_scheduler_macros.svh */
// Assertion macros for the timed diverter scheduler.
// Included by files that check their own logic; no other dependencies.
`ifndef TIMED_DIVERTER_SCHEDULER_MACROS_SVH
`define TIMED_DIVERTER_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define TDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define TDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/tds_pkg.sv */
// Shared types and constants for the timed diverter scheduler.
// No dependencies; used by the controller and the top level.
package tds_pkg;

	localparam int TICK_W    = 32;
	localparam int DELAY_W   = 31;
	localparam int CODE_W    = 8;
	localparam int SLOT_W    = 4;
	localparam int CFG_IDX_W = 1;

	// Recognized destination codes.
	localparam logic [CODE_W-1:0] DEST_A = 8'h01;
	localparam logic [CODE_W-1:0] DEST_B = 8'h02;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_A = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_B = 1'd1;

	localparam logic [DELAY_W-1:0] DELAY_A_RESET = 31'd4000;
	localparam logic [DELAY_W-1:0] DELAY_B_RESET = 31'd7500;

	typedef enum logic [1:0] {
		DIV_NONE = 2'd0,
		DIV_A    = 2'd1,
		DIV_B    = 2'd2
	} div_t;

	// One slot of the package table.
	typedef struct packed {
		logic [TICK_W-1:0] due;
		div_t              div;
		logic              done;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Finished tick from the controller to the output register.
	typedef struct packed {
		logic              load;
		logic              fire_a;
		logic              fire_b;
		logic [SLOT_W-1:0] write_slot;
	} result_t;

endpackage

/* design/tds_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/tds_ctrl.sv */
// Tick sequencer: scans the package table one slot per cycle, writes back fired
// slots and the new recognition. Depends on tds_pkg and tds_ram.
module tds_ctrl
	import tds_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               belt_running,
	input  logic               new_package,
	input  logic [CODE_W-1:0]  dest_code,
	input  logic [DELAY_W-1:0] delay_a,
	input  logic [DELAY_W-1:0] delay_b,
	input  logic               out_free,
	output result_t            res
);

	localparam int PW = $clog2(TABLE_DEPTH);
	localparam int EW = $bits(entry_t);
	localparam logic [PW-1:0] LAST_SLOT = PW'(TABLE_DEPTH - 1);

	state_t            state_q, state_d;
	logic [TICK_W-1:0] tick_q;
	logic              belt_q, new_q;
	logic [CODE_W-1:0] code_q;
	logic [PW-1:0]     idx_q, ptr_q, ptr_next;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic              en_a_q, en_b_q;
	logic              vld_s1, live_s1;
	logic [PW-1:0]     addr_s1;

	logic              rd_en, wr_en, hit, load;
	logic [PW-1:0]     wr_addr;
	entry_t            wr_data, rd_entry, new_entry;
	logic [EW-1:0]     rd_data;
	logic [TICK_W-1:0] due_diff;
	logic [PW+SLOT_W-1:0] slot_ext;

	tds_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign rd_entry = entry_t'(rd_data);
	assign due_diff = tick_q - rd_entry.due;
	assign in_stall = (state_q != ST_IDLE);

	// A slot fires when live, pending, assigned, and its due time has been reached.
	assign hit = vld_s1 && live_s1 && !rd_entry.done && (rd_entry.div != DIV_NONE)
		&& !due_diff[TICK_W-1];

	assign ptr_next = (ptr_q == LAST_SLOT) ? '0 : ptr_q + PW'(1);

	// Entry for the recognition that arrived with this tick.
	always_comb begin
		new_entry.done = 1'b0;
		unique case (code_q)
			DEST_A: begin
				new_entry.due = tick_q + {1'b0, delay_a};
				new_entry.div = DIV_A;
			end
			DEST_B: begin
				new_entry.due = tick_q + {1'b0, delay_b};
				new_entry.div = DIV_B;
			end
			default: begin
				new_entry.due = '0;
				new_entry.div = DIV_NONE;
			end
		endcase
	end

	// Next state and table port control.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (idx_q == LAST_SLOT) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Fired slots write back during the scan; the new entry only at the end,
		// so the two never share a cycle.
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = rd_entry;
		if (hit) begin
			wr_en        = 1'b1;
			wr_data.done = 1'b1;
		end else if (load && new_q) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q;
			wr_data = new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Tick counter, scan index, write pointer and slot valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			idx_q   <= '0;
			ptr_q   <= '0;
			valid_q <= '0;
		end else begin
			if (state_q == ST_IDLE && in_valid) begin
				tick_q <= tick_q + TICK_W'(1);
				idx_q  <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + PW'(1);
			end
			if (load && new_q) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q          <= ptr_next;
			end
		end
	end

	// Word fields held for the length of the tick.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			belt_q <= belt_running;
			new_q  <= new_package;
			code_q <= dest_code;
		end
	end

	// Read pipeline stage: slot number and its valid bit travel with the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			live_s1 <= 1'b0;
		end else begin
			vld_s1  <= rd_en;
			live_s1 <= valid_q[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
	end

	// Diverter enables: set by fired slots, cleared when emitted on a running belt.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_a_q <= 1'b0;
			en_b_q <= 1'b0;
		end else if (hit) begin
			if (rd_entry.div == DIV_A) begin
				en_a_q <= 1'b1;
			end
			if (rd_entry.div == DIV_B) begin
				en_b_q <= 1'b1;
			end
		end else if (load && belt_q) begin
			en_a_q <= 1'b0;
			en_b_q <= 1'b0;
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, (new_q ? ptr_next : ptr_q)};

	assign res.load       = load;
	assign res.fire_a     = belt_q & en_a_q;
	assign res.fire_b     = belt_q & en_b_q;
	assign res.write_slot = slot_ext[SLOT_W-1:0];

endmodule

/* design/timed_diverter_scheduler.sv */
// Channel   Direction  Handshake            Word fields
// in        input      in_valid / in_stall   belt_running, new_package, dest_code
// out       output     out_valid / out_stall fire_a, fire_b, write_slot
// cfg       input      cfg_wr_en             cfg_index, cfg_wdata
//
// A tick is paced by the table memory's single read port: one slot is read per cycle
// in the scan, followed by a pipeline drain, a finish and an idle state.
// Reset clears the slot valid bits at once; no clearing pass, a word is taken right away.
// A stalled result is held in the output register while the next tick runs; the
// tick then waits at its finish until the register is free.
// Top level of the timed diverter scheduler: configuration registers, output
// register and assertions. Depends on tds_pkg, tds_ctrl and the macros header.
`include "timed_diverter_scheduler_macros.svh"

module timed_diverter_scheduler
	import tds_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 belt_running,
	input  logic                 new_package,
	input  logic [CODE_W-1:0]    dest_code,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 fire_a,
	output logic                 fire_b,
	output logic [SLOT_W-1:0]    write_slot,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELAY_W-1:0]   cfg_wdata
);

	logic [DELAY_W-1:0] delay_a_q, delay_b_q;
	logic               out_free;
	result_t            res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_a_q <= DELAY_A_RESET;
			delay_b_q <= DELAY_B_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DELAY_A: delay_a_q <= cfg_wdata;
				REG_DELAY_B: delay_b_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	tds_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.belt_running (belt_running),
		.new_package  (new_package),
		.dest_code    (dest_code),
		.delay_a      (delay_a_q),
		.delay_b      (delay_b_q),
		.out_free     (out_free),
		.res          (res)
	);

	// Output register: free when empty or when its word is taken this cycle.
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			fire_a     <= res.fire_a;
			fire_b     <= res.fire_b;
			write_slot <= res.write_slot;
		end
	end

	// A result never overwrites a word that is still waiting.
	`TDS_ASSERT_IMPLY(a_load_when_free, clk, arst_n, res.load, !out_valid || !out_stall)
	// A tick never completes in the cycle after it is taken.
	`TDS_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && !in_stall, !res.load)
	// After a result is loaded the block is ready for the next word.
	`TDS_ASSERT_NEXT(a_ready_after_load, clk, arst_n, res.load, !in_stall)

endmodule
